// File: hw/rtl/bcpg_pkg.sv
// Shared widths, register indexes and reset values for the blink code generator.
`default_nettype none

package bcpg_pkg;

    localparam int TIMER_WIDTH = 16;
    localparam int COUNT_WIDTH = 8;

    localparam int CFG_IDX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH = 16;

    // register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_PULSE_COUNT = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_BREAK_TICKS = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_HALF_TICKS  = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SYNC_HIGH   = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SYNC_LOW    = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_IDLE_HIGH   = 3'd5;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_IDLE_LOW    = 3'd6;

    // register reset values
    localparam logic [7:0]  RST_PULSE_COUNT = 8'd0;
    localparam logic [15:0] RST_BREAK_TICKS = 16'd2500;
    localparam logic [15:0] RST_HALF_TICKS  = 16'd100;
    localparam logic [15:0] RST_SYNC_HIGH   = 16'd50;
    localparam logic [15:0] RST_SYNC_LOW    = 16'd200;
    localparam logic [15:0] RST_IDLE_HIGH   = 16'd100;
    localparam logic [15:0] RST_IDLE_LOW    = 16'd300;

    // timer values after reset
    localparam logic [TIMER_WIDTH-1:0] INIT_MAIN_TICKS = TIMER_WIDTH'(100);
    localparam logic [TIMER_WIDTH-1:0] INIT_SYNC_TICKS = TIMER_WIDTH'(300);

endpackage

`default_nettype wire

// File: hw/rtl/bcpg_if.sv
// Request, result and configuration channel interfaces of the blink code generator.
`default_nettype none

interface bcpg_req_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink   (input valid, input tick, output ready);
endinterface

interface bcpg_rsp_if;
    logic       valid;
    logic       ready;
    logic       level;
    logic [1:0] phase;
    logic [7:0] pulses_left;

    modport source (output valid, output level, output phase, output pulses_left, input ready);
    modport sink   (input valid, input level, input phase, input pulses_left, output ready);
endinterface

interface bcpg_cfg_if;
    import bcpg_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [CFG_IDX_WIDTH-1:0]  index;
    logic [CFG_DATA_WIDTH-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/blink_code_pulse_generator_unit.sv
// Top level of the LED blink code generator: timers, burst sequencer, result register.
//
//   channel  dir  modport  payload
//   i_req    in   sink     tick (1)
//   o_rsp    out  source   level (1), phase (2), pulses_left (8)
//   i_cfg    in   sink     index (3), data (16)
//
// One request is taken per clock while the result register is free; its result appears in the
// result register the next cycle. Both timers and the sequencer update in that same cycle.
// Requests are taken while the result register is empty or being drained.
// A stalled result holds the sequencer, timers and result register; config writes are always ready.
// i_rst_n is synchronous, active low: config registers, timers, sequencer and result valid go to reset values.
`default_nettype none

module blink_code_pulse_generator_unit
    import bcpg_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    bcpg_req_if.sink    i_req,
    bcpg_rsp_if.source  o_rsp,
    bcpg_cfg_if.sink    i_cfg
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_BREAK = 2'd1,
        PH_COUNT = 2'd2
    } t_phase;

    // configuration registers
    logic [7:0]  r_pulse_count;
    logic [15:0] r_break_ticks;
    logic [15:0] r_half_ticks;
    logic [15:0] r_sync_high;
    logic [15:0] r_sync_low;
    logic [15:0] r_idle_high;
    logic [15:0] r_idle_low;

    // sequencer state
    t_phase                  r_phase,     n_phase;
    logic                    r_burst,     n_burst;
    logic                    r_sync,      n_sync;
    logic [COUNT_WIDTH-1:0]  r_remaining, n_remaining;
    logic [TIMER_WIDTH-1:0]  r_main_tmr,  n_main_tmr;
    logic [TIMER_WIDTH-1:0]  r_sync_tmr,  n_sync_tmr;

    // result register
    logic       r_out_valid;
    logic       r_level,  n_level;
    logic [1:0] r_phase_out;
    logic [7:0] r_pulses;

    logic                   req_take;
    logic [COUNT_WIDTH-1:0] count;
    logic [TIMER_WIDTH-1:0] main_dec;
    logic [TIMER_WIDTH-1:0] sync_dec;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign req_take    = i_req.valid && i_req.ready;

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.level       = r_level;
    assign o_rsp.phase       = r_phase_out;
    assign o_rsp.pulses_left = r_pulses;

    // configuration writes; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_count <= RST_PULSE_COUNT;
            r_break_ticks <= RST_BREAK_TICKS;
            r_half_ticks  <= RST_HALF_TICKS;
            r_sync_high   <= RST_SYNC_HIGH;
            r_sync_low    <= RST_SYNC_LOW;
            r_idle_high   <= RST_IDLE_HIGH;
            r_idle_low    <= RST_IDLE_LOW;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_PULSE_COUNT: r_pulse_count <= i_cfg.data[7:0];
                CFG_BREAK_TICKS: r_break_ticks <= i_cfg.data;
                CFG_HALF_TICKS:  r_half_ticks  <= i_cfg.data;
                CFG_SYNC_HIGH:   r_sync_high   <= i_cfg.data;
                CFG_SYNC_LOW:    r_sync_low    <= i_cfg.data;
                CFG_IDLE_HIGH:   r_idle_high   <= i_cfg.data;
                CFG_IDLE_LOW:    r_idle_low    <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign count = COUNT_WIDTH'(r_pulse_count);

    // a tick counts both timers down, stopping at zero
    assign main_dec = (i_req.tick && (r_main_tmr != '0)) ? r_main_tmr - 1'b1 : r_main_tmr;
    assign sync_dec = (i_req.tick && (r_sync_tmr != '0)) ? r_sync_tmr - 1'b1 : r_sync_tmr;

    always_comb begin
        n_phase     = r_phase;
        n_burst     = r_burst;
        n_sync      = r_sync;
        n_remaining = r_remaining;
        n_main_tmr  = main_dec;
        n_sync_tmr  = sync_dec;

        // free-running sync blinker
        if (sync_dec == '0) begin
            n_sync     = !r_sync;
            n_sync_tmr = TIMER_WIDTH'(n_sync ? r_sync_high : r_sync_low);
        end

        if (main_dec == '0) begin
            unique case (r_phase)
                PH_IDLE: begin
                    // idle check timer toggles the hidden level and polls the count
                    n_burst    = !r_burst;
                    n_main_tmr = TIMER_WIDTH'(n_burst ? r_idle_high : r_idle_low);
                    if (count != '0) begin
                        n_phase    = PH_BREAK;
                        n_burst    = 1'b0;
                        n_main_tmr = TIMER_WIDTH'(r_break_ticks);
                    end
                end
                PH_BREAK: begin
                    n_phase     = PH_COUNT;
                    n_remaining = count;
                    n_main_tmr  = TIMER_WIDTH'(r_half_ticks);
                end
                PH_COUNT: begin
                    n_burst    = !r_burst;
                    n_main_tmr = TIMER_WIDTH'(r_half_ticks);
                    // end of a high half closes one pulse
                    if (!n_burst) begin
                        if (count == '0) begin
                            n_phase     = PH_IDLE;
                            n_remaining = '0;
                        end else begin
                            n_remaining = r_remaining - 1'b1;
                            if (n_remaining == '0) begin
                                n_phase    = PH_BREAK;
                                n_burst    = 1'b0;
                                n_main_tmr = TIMER_WIDTH'(r_break_ticks);
                            end
                        end
                    end
                end
                default: ;  // unused phase code holds the sequencer state; the timers still run
            endcase
        end

        n_level = (n_phase == PH_IDLE) ? n_sync : n_burst;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_burst     <= 1'b0;
            r_sync      <= 1'b0;
            r_remaining <= '0;
            r_main_tmr  <= INIT_MAIN_TICKS;
            r_sync_tmr  <= INIT_SYNC_TICKS;
            r_out_valid <= 1'b0;
        end else begin
            if (req_take) begin
                r_phase     <= n_phase;
                r_burst     <= n_burst;
                r_sync      <= n_sync;
                r_remaining <= n_remaining;
                r_main_tmr  <= n_main_tmr;
                r_sync_tmr  <= n_sync_tmr;
                r_level     <= n_level;
                r_phase_out <= 2'(n_phase);
                r_pulses    <= 8'(n_remaining);
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTH
    // every accepted request leaves a result behind
    a_req_gives_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_take |=> r_out_valid)
        else $error("accepted request produced no result");

    // idle always clears the pulse counter
    a_idle_no_pulses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_remaining == '0))
        else $error("pulses left while idle");

    // the LED stays dark during a break
    a_break_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BREAK) |-> !r_burst)
        else $error("burst level high during break");

    // sequencer state moves only on an accepted request
    a_state_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !req_take |=> $stable(r_phase) && $stable(r_remaining) && $stable(r_main_tmr))
        else $error("sequencer moved without a request");
`endif

endmodule

`default_nettype wire

// File: test/tb_blink_code_pulse_generator_unit.sv
// Self-checking testbench for blink_code_pulse_generator_unit: tick requests against a predictor.
`default_nettype none

module tb_blink_code_pulse_generator_unit;
    import bcpg_pkg::*;

    // Sequencer phases as reported on the result channel; code 3 is never produced.
    typedef enum logic [1:0] {
        SEQ_IDLE  = 2'd0,
        SEQ_BREAK = 2'd1,
        SEQ_COUNT = 2'd2
    } t_seq_phase;

    // Handshake pressure applied during a stretch of requests.
    typedef enum int {
        FLOW_FULL,
        FLOW_SRC_SLOW,
        FLOW_SNK_SLOW,
        FLOW_BOTH_SLOW
    } t_flow_mode;

    typedef struct packed {
        logic       level;
        logic [1:0] phase;
        logic [7:0] pulses_left;
    } t_led_status;

    typedef struct {
        logic [CFG_IDX_WIDTH-1:0]  idx;
        logic [CFG_DATA_WIDTH-1:0] data;
    } t_reg_write;

    // Index past the register file; the block must ignore writes to it.
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_UNMAPPED = 3'd7;

    localparam int SLOW_PCT     = 87;
    localparam int BOTH_PCT     = 26;
    localparam int TICK_ONE_PCT = 75;

    logic i_clk = 1'b0;
    logic i_rst_n;

    always #5 i_clk = ~i_clk;

    bcpg_req_if req_ch ();
    bcpg_rsp_if rsp_ch ();
    bcpg_cfg_if cfg_ch ();

    blink_code_pulse_generator_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    // ------------------------------------------------------------------
    // Blinker predictor: shadow registers plus timers and sequencer state.
    // ------------------------------------------------------------------
    logic [7:0]             reg_pulse_count;
    logic [15:0]            reg_break, reg_half, reg_sync_high, reg_sync_low;
    logic [15:0]            reg_idle_high, reg_idle_low;
    logic [TIMER_WIDTH-1:0] main_cnt, sync_cnt;
    logic [COUNT_WIDTH-1:0] pulses_rem;
    t_seq_phase             seq_ph;
    logic                   burst_lvl, sync_lvl;

    // Bookkeeping shared by the stimulus, the drivers and the monitor.
    logic        pending_ticks[$];   // requests not yet accepted
    t_led_status status_due[$];      // predicted results, oldest first
    t_reg_write  reg_writes[$];      // register writes not yet accepted
    bit          req_live = 1'b0;    // a request is on the channel
    bit          cfg_live = 1'b0;    // a register write is on the channel
    t_flow_mode  flow = FLOW_FULL;
    int          rsp_hold = 0;       // forced receiver stall, in cycles
    int          mismatches = 0;

    task automatic reset_blinker();
        reg_pulse_count = RST_PULSE_COUNT;
        reg_break       = RST_BREAK_TICKS;
        reg_half        = RST_HALF_TICKS;
        reg_sync_high   = RST_SYNC_HIGH;
        reg_sync_low    = RST_SYNC_LOW;
        reg_idle_high   = RST_IDLE_HIGH;
        reg_idle_low    = RST_IDLE_LOW;
        main_cnt        = INIT_MAIN_TICKS;
        sync_cnt        = INIT_SYNC_TICKS;
        pulses_rem      = '0;
        seq_ph          = SEQ_IDLE;
        burst_lvl       = 1'b0;
        sync_lvl        = 1'b0;
    endtask

    task automatic apply_reg_write(input logic [CFG_IDX_WIDTH-1:0] idx,
                                   input logic [CFG_DATA_WIDTH-1:0] d);
        case (idx)
            CFG_PULSE_COUNT: reg_pulse_count = d[7:0];
            CFG_BREAK_TICKS: reg_break       = d;
            CFG_HALF_TICKS:  reg_half        = d;
            CFG_SYNC_HIGH:   reg_sync_high   = d;
            CFG_SYNC_LOW:    reg_sync_low    = d;
            CFG_IDLE_HIGH:   reg_idle_high   = d;
            CFG_IDLE_LOW:    reg_idle_low    = d;
            default: ;
        endcase
    endtask

    task automatic enter_break();
        seq_ph    = SEQ_BREAK;
        main_cnt  = TIMER_WIDTH'(reg_break);
        burst_lvl = 1'b0;
    endtask

    // One expiry of the main timer moves the burst sequencer by one step.
    task automatic run_sequencer();
        logic [COUNT_WIDTH-1:0] count;
        count = COUNT_WIDTH'(reg_pulse_count);
        case (seq_ph)
            SEQ_IDLE: begin
                // idle check: toggle the internal level, then look at the count
                burst_lvl = ~burst_lvl;
                main_cnt  = TIMER_WIDTH'(burst_lvl ? reg_idle_high : reg_idle_low);
                if (count != '0)
                    enter_break();
            end
            SEQ_BREAK: begin
                // the count is latched here, so a change during the break takes effect
                seq_ph     = SEQ_COUNT;
                pulses_rem = count;
                main_cnt   = TIMER_WIDTH'(reg_half);
            end
            SEQ_COUNT: begin
                burst_lvl = ~burst_lvl;
                main_cnt  = TIMER_WIDTH'(reg_half);
                if (!burst_lvl) begin
                    if (count == '0) begin
                        seq_ph     = SEQ_IDLE;
                        pulses_rem = '0;
                    end else begin
                        // zero left here wraps to all ones
                        pulses_rem = pulses_rem - 1'b1;
                        if (pulses_rem == '0)
                            enter_break();
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic advance_blinker(input logic tick, output t_led_status st);
        if (tick) begin
            if (main_cnt != '0) main_cnt = main_cnt - 1'b1;
            if (sync_cnt != '0) sync_cnt = sync_cnt - 1'b1;
        end
        // sync blinker first, then the sequencer; a zero reload fires on the next request
        if (sync_cnt == '0) begin
            sync_lvl = ~sync_lvl;
            sync_cnt = TIMER_WIDTH'(sync_lvl ? reg_sync_high : reg_sync_low);
        end
        if (main_cnt == '0)
            run_sequencer();
        st.level       = (seq_ph == SEQ_IDLE) ? sync_lvl : burst_lvl;
        st.phase       = seq_ph;
        st.pulses_left = 8'(pulses_rem);
    endtask

    // ------------------------------------------------------------------
    // Monitor: everything accepted at a rising edge is handled here.
    // Results are checked before the new request is predicted, so a result
    // taken in the same cycle is matched against older requests only.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : track
        t_led_status want, seen, new_status;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                apply_reg_write(cfg_ch.index, cfg_ch.data);
                void'(reg_writes.pop_front());
                cfg_live = 1'b0;
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                seen.level       = rsp_ch.level;
                seen.phase       = rsp_ch.phase;
                seen.pulses_left = rsp_ch.pulses_left;
                if (status_due.size() == 0) begin
                    $error("result with no request outstanding: level %0d phase %0d pulses_left %0d",
                           seen.level, seen.phase, seen.pulses_left);
                    mismatches++;
                end else begin
                    want = status_due.pop_front();
                    if (seen.level !== want.level) begin
                        $error("level: expected %0d, got %0d", want.level, seen.level);
                        mismatches++;
                    end
                    if (seen.phase !== want.phase) begin
                        $error("phase: expected %0d, got %0d", want.phase, seen.phase);
                        mismatches++;
                    end
                    if (seen.pulses_left !== want.pulses_left) begin
                        $error("pulses_left: expected %0d, got %0d",
                               want.pulses_left, seen.pulses_left);
                        mismatches++;
                    end
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                advance_blinker(req_ch.tick, new_status);
                status_due.push_back(new_status);
                void'(pending_ticks.pop_front());
                req_live = 1'b0;
            end
        end
    end

    function automatic bit sender_rests();
        case (flow)
            FLOW_SRC_SLOW:  return $urandom_range(99) < SLOW_PCT;
            FLOW_BOTH_SLOW: return $urandom_range(99) < BOTH_PCT;
            default:        return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_rests();
        case (flow)
            FLOW_SNK_SLOW:  return $urandom_range(99) < SLOW_PCT;
            FLOW_BOTH_SLOW: return $urandom_range(99) < BOTH_PCT;
            default:        return 1'b0;
        endcase
    endfunction

    // Request driver: an offered request stays on the channel until it is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_live) begin
            if (pending_ticks.size() > 0 && !sender_rests()) begin
                req_ch.valid <= 1'b1;
                req_ch.tick  <= pending_ticks[0];
                req_live = 1'b1;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Register write driver, never throttled.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cfg_ch.valid <= 1'b0;
        end else if (!cfg_live) begin
            if (reg_writes.size() > 0) begin
                cfg_ch.valid <= 1'b1;
                cfg_ch.index <= reg_writes[0].idx;
                cfg_ch.data  <= reg_writes[0].data;
                cfg_live = 1'b1;
            end else begin
                cfg_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver; a forced hold is counted down here, one cycle per edge.
    always @(negedge i_clk) begin
        if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= !receiver_rests();
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Returns once nothing is queued, on the wires, or still owed by the block.
    task automatic drain();
        while (pending_ticks.size() != 0 || status_due.size() != 0 ||
               reg_writes.size() != 0 || req_live || cfg_live)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] d);
        t_reg_write w;
        w.idx  = idx;
        w.data = d;
        reg_writes.push_back(w);
    endtask

    task automatic push_ticks(input int n, input int pct_one);
        repeat (n) pending_ticks.push_back($urandom_range(99) < pct_one);
    endtask

    // Single-steps the block until the predicted sequencer reaches a phase.
    task automatic step_until(input t_seq_phase target, input logic t);
        int guard;
        guard = 0;
        while (seq_ph != target && guard < 64) begin
            pending_ticks.push_back(t);
            drain();
            guard++;
        end
    endtask

    // Mostly short timers so bursts complete often; sometimes zero or longer.
    function automatic logic [CFG_DATA_WIDTH-1:0] rand_timer();
        case ($urandom_range(9))
            0:       return '0;
            1:       return CFG_DATA_WIDTH'($urandom_range(40, 7));
            default: return CFG_DATA_WIDTH'($urandom_range(6, 1));
        endcase
    endfunction

    function automatic logic [CFG_DATA_WIDTH-1:0] rand_count();
        case ($urandom_range(15))
            0, 1, 2, 3: return '0;
            4:          return 16'hFFFF;   // only the low byte is kept
            5:          return CFG_DATA_WIDTH'($urandom_range(255, 4));
            default:    return CFG_DATA_WIDTH'($urandom_range(3, 1));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n      = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.tick  = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        reset_blinker();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset state and defaults: a few requests with both tick values.
        pending_ticks.push_back(1'b1);
        pending_ticks.push_back(1'b0);
        pending_ticks.push_back(1'b1);
        pending_ticks.push_back(1'b1);
        pending_ticks.push_back(1'b0);
        drain();

        // Shorten every timer, then tick through the long timer values left by reset.
        write_reg(CFG_BREAK_TICKS, 16'd1);
        write_reg(CFG_HALF_TICKS,  16'd1);
        write_reg(CFG_SYNC_HIGH,   16'd1);
        write_reg(CFG_SYNC_LOW,    16'd1);
        write_reg(CFG_IDLE_HIGH,   16'd1);
        write_reg(CFG_IDLE_LOW,    16'd1);
        drain();
        push_ticks(310, 100);
        drain();

        // Zero-length timers: every request fires both timers, even with tick low.
        write_reg(CFG_PULSE_COUNT, 16'd2);
        write_reg(CFG_BREAK_TICKS, 16'd0);
        write_reg(CFG_HALF_TICKS,  16'd0);
        write_reg(CFG_SYNC_HIGH,   16'd0);
        write_reg(CFG_SYNC_LOW,    16'd0);
        write_reg(CFG_IDLE_HIGH,   16'd0);
        write_reg(CFG_IDLE_LOW,    16'd0);
        drain();
        step_until(SEQ_BREAK, 1'b1);

        // Count cleared during the break: the burst starts with nothing left.
        write_reg(CFG_PULSE_COUNT, 16'd0);
        drain();
        step_until(SEQ_COUNT, 1'b0);
        pending_ticks.push_back(1'b0);
        drain();

        // Count set again before the high half ends: remaining wraps to all ones.
        write_reg(CFG_PULSE_COUNT, 16'd3);
        drain();
        pending_ticks.push_back(1'b0);
        pending_ticks.push_back(1'b1);
        pending_ticks.push_back(1'b0);
        pending_ticks.push_back(1'b0);
        drain();

        // Zero count ends the burst at the next low half and returns to idle.
        write_reg(CFG_PULSE_COUNT, 16'd0);
        drain();
        step_until(SEQ_IDLE, 1'b0);

        // Random phases: new register values between phases, rotating pressure.
        for (int p = 0; p < 34; p++) begin
            drain();
            if (p == 0 || $urandom_range(1)) write_reg(CFG_PULSE_COUNT, rand_count());
            if (p == 0 || $urandom_range(1)) write_reg(CFG_BREAK_TICKS, rand_timer());
            if (p == 0 || $urandom_range(1)) write_reg(CFG_HALF_TICKS,  rand_timer());
            if (p == 0 || $urandom_range(1)) write_reg(CFG_SYNC_HIGH,   rand_timer());
            if (p == 0 || $urandom_range(1)) write_reg(CFG_SYNC_LOW,    rand_timer());
            if (p == 0 || $urandom_range(1)) write_reg(CFG_IDLE_HIGH,   rand_timer());
            if (p == 0 || $urandom_range(1)) write_reg(CFG_IDLE_LOW,    rand_timer());
            if (p == 1 || $urandom_range(7) == 0)
                write_reg(CFG_UNMAPPED, CFG_DATA_WIDTH'($urandom));
            drain();
            flow = t_flow_mode'(p % 4);
            if (p == 5) begin
                // receiver holds off while requests keep coming: input must back up
                flow     = FLOW_FULL;
                rsp_hold = 80;
            end
            if (p == 10) begin
                // sender stops mid-phase until every result is back
                push_ticks(20, TICK_ONE_PCT);
                drain();
                push_ticks(25, TICK_ONE_PCT);
            end else begin
                push_ticks(45, TICK_ONE_PCT);
            end
        end
        drain();

        // Largest values: full-width loads on the next expiries.
        flow = FLOW_FULL;
        write_reg(CFG_PULSE_COUNT, 16'd255);
        write_reg(CFG_BREAK_TICKS, 16'hFFFF);
        write_reg(CFG_HALF_TICKS,  16'hFFFF);
        write_reg(CFG_SYNC_HIGH,   16'hFFFF);
        write_reg(CFG_SYNC_LOW,    16'hFFFF);
        write_reg(CFG_IDLE_HIGH,   16'hFFFF);
        write_reg(CFG_IDLE_LOW,    16'hFFFF);
        drain();
        push_ticks(20, 100);
        drain();

        // Anything arriving now is an extra result.
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog.
    initial begin
        #(10 * 1_000_000);
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
